// File: hdl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Types and constants shared by the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int VALUE_W = 48;
    localparam int WORD_W  = 32;
    localparam int NIB_W   = 4;

    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ASCII_X          = 8'd120;
    localparam logic [7:0] ASCII_PERCENT    = 8'd37;
    localparam logic [7:0] LOWER_HEX_OFFSET = 8'd87;
    localparam logic [7:0] UPPER_HEX_OFFSET = 8'd55;
    localparam logic [3:0] DEC_BASE         = 4'd10;

    // Reciprocal of ten scaled by 2^35; exact quotient for any 32-bit value.
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        A_SDEC    = 3'd0,
        A_UDEC    = 3'd1,
        A_HEX_LO  = 3'd2,
        A_HEX_UP  = 3'd3,
        A_POINTER = 3'd4,
        A_CHAR    = 3'd5,
        A_PERCENT = 3'd6
    } t_action;

    typedef struct packed {
        logic               empty;
        logic               neg;
        logic               has_digits;
        logic               decimal;
        logic               upper;
        logic               pre_ptr;
        logic [1:0]         pre_len;
        logic [7:0]         lit;
        logic [VALUE_W-1:0] value;
    } t_cmd;

endpackage

// File: hdl/ita_if.sv
// ----------------------------------------------------------------------------
// ita_req_if / ita_chr_if
// Valid/ready channels for conversion requests and output characters.
// ----------------------------------------------------------------------------
interface ita_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [47:0] value;
    logic        precision_zero;

    modport source (output valid, output action, output value, output precision_zero,
                    input ready);
    modport sink   (input valid, input action, input value, input precision_zero,
                    output ready);
endinterface

interface ita_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_negative;
    logic       empty_res;
    logic       last;

    modport source (output valid, output out_char, output is_negative, output empty_res,
                    output last, input ready);
    modport sink   (input valid, input out_char, input is_negative, input empty_res,
                    input last, output ready);
endinterface

// File: hdl/ita_front.sv
// ----------------------------------------------------------------------------
// ita_front
// Accepts requests and classifies them into prefix and digit work.
// ----------------------------------------------------------------------------
module ita_front #(
    parameter int POINTER_DIGITS = 12
) (
    ita_req_if.sink        i_req,
    input  logic           i_q_ready,
    output logic           o_q_valid,
    output ita_pkg::t_cmd  o_q_cmd
);

    localparam int PTR_BITS = (ita_pkg::NIB_W * POINTER_DIGITS < ita_pkg::VALUE_W)
                              ? ita_pkg::NIB_W * POINTER_DIGITS : ita_pkg::VALUE_W;
    localparam logic [ita_pkg::VALUE_W-1:0] PTR_MASK =
        {ita_pkg::VALUE_W{1'b1}} >> (ita_pkg::VALUE_W - PTR_BITS);

    logic [ita_pkg::WORD_W-1:0]  word;
    logic [ita_pkg::WORD_W-1:0]  mag;
    logic                        word_neg;
    logic [ita_pkg::VALUE_W-1:0] ptr_val;
    ita_pkg::t_cmd               cmd;

    assign word     = i_req.value[ita_pkg::WORD_W-1:0];
    assign word_neg = (i_req.action == ita_pkg::A_SDEC) && word[ita_pkg::WORD_W-1];
    assign mag      = word_neg ? (~word + 1'b1) : word;
    assign ptr_val  = i_req.value & PTR_MASK;

    always_comb begin
        cmd = '0;
        unique case (i_req.action) inside
            ita_pkg::A_SDEC, ita_pkg::A_UDEC, ita_pkg::A_HEX_LO, ita_pkg::A_HEX_UP: begin
                if (mag == '0) begin
                    if (i_req.precision_zero) begin
                        cmd.empty = 1'b1;
                    end else begin
                        cmd.pre_len = 2'd1;
                        cmd.lit     = ita_pkg::ASCII_ZERO;
                    end
                end else begin
                    cmd.has_digits = 1'b1;
                    cmd.neg        = word_neg;
                    cmd.decimal    = (i_req.action == ita_pkg::A_SDEC) ||
                                     (i_req.action == ita_pkg::A_UDEC);
                    cmd.upper      = (i_req.action == ita_pkg::A_HEX_UP);
                    cmd.value      = {{(ita_pkg::VALUE_W - ita_pkg::WORD_W){1'b0}}, mag};
                end
            end
            ita_pkg::A_POINTER: begin
                cmd.pre_ptr = 1'b1;
                if (i_req.value == '0) begin
                    cmd.pre_len = i_req.precision_zero ? 2'd2 : 2'd3;
                end else if (ptr_val == '0) begin
                    cmd.pre_len = 2'd3;
                end else begin
                    cmd.pre_len    = 2'd2;
                    cmd.has_digits = 1'b1;
                    cmd.value      = ptr_val;
                end
            end
            ita_pkg::A_CHAR: begin
                cmd.pre_len = 2'd1;
                cmd.lit     = i_req.value[7:0];
            end
            ita_pkg::A_PERCENT: begin
                cmd.pre_len = 2'd1;
                cmd.lit     = ita_pkg::ASCII_PERCENT;
            end
            default: begin
                cmd.empty = 1'b1;
            end
        endcase
    end

    assign i_req.ready = i_q_ready;
    assign o_q_valid   = i_req.valid;
    assign o_q_cmd     = cmd;

endmodule

// File: hdl/ita_queue.sv
// ----------------------------------------------------------------------------
// ita_queue
// Short command queue between the classifier and the character generator.
// ----------------------------------------------------------------------------
module ita_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ita_pkg::t_cmd  i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ita_pkg::t_cmd  o_pop_cmd
);

    localparam int PW = $clog2(ita_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ita_pkg::QUEUE_DEPTH + 1);

    ita_pkg::t_cmd r_mem [ita_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(ita_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr_ptr] <= i_push_cmd;
                r_wr_ptr        <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ita_pkg::QUEUE_DEPTH))
        else $error("Command queue count exceeds its depth.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("Command queue lost a pushed command.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Command queue pointers disagree while empty.");

endmodule

// File: hdl/ita_back.sv
// ----------------------------------------------------------------------------
// ita_back
// Extracts digits into a stack and emits prefix and digit characters.
// ----------------------------------------------------------------------------
module ita_back #(
    parameter int DEPTH = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  ita_pkg::t_cmd  i_q_cmd,
    ita_chr_if.source      o_chr
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXTRACT,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic [ita_pkg::VALUE_W-1:0] r_v;
    logic                        r_decimal;
    logic                        r_upper;
    logic                        r_neg;
    logic                        r_empty;
    logic                        r_pre_ptr;
    logic [1:0]                  r_pre_left;
    logic [1:0]                  r_pre_idx;
    logic [7:0]                  r_lit;
    logic [CW-1:0]               r_cnt;
    logic [3:0]                  r_stack [DEPTH];
    logic                        r_ov;
    logic [7:0]                  r_och;
    logic                        r_oneg;
    logic                        r_oempty;
    logic                        r_olast;

    logic [2*ita_pkg::WORD_W-1:0] prod;
    logic [ita_pkg::WORD_W-1:0]   quot;
    logic [ita_pkg::WORD_W-1:0]   rem;
    logic [3:0]                   digit;
    logic [ita_pkg::VALUE_W-1:0]  v_next;
    logic                         out_free;
    logic                         is_last;
    logic [7:0]                   pre_char;
    logic [7:0]                   dig_char;
    logic [7:0]                   emit_char;

    assign prod  = r_v[ita_pkg::WORD_W-1:0] * ita_pkg::DEC_RECIP;
    assign quot  = ita_pkg::WORD_W'(prod >> ita_pkg::DEC_SHIFT);
    assign rem   = r_v[ita_pkg::WORD_W-1:0] - ((quot << 3) + (quot << 1));
    assign digit = r_decimal ? rem[3:0] : r_v[3:0];
    assign v_next = r_decimal
                  ? {{(ita_pkg::VALUE_W - ita_pkg::WORD_W){1'b0}}, quot}
                  : (r_v >> ita_pkg::NIB_W);

    assign out_free = !r_ov || o_chr.ready;
    assign is_last  = r_empty || ((r_pre_left == 2'd1) && (r_cnt == '0)) ||
                      ((r_pre_left == 2'd0) && (r_cnt == CW'(1)));

    assign pre_char = r_pre_ptr
                    ? ((r_pre_idx == 2'd1) ? ita_pkg::ASCII_X : ita_pkg::ASCII_ZERO)
                    : r_lit;

    always_comb begin
        if (r_stack[0] < ita_pkg::DEC_BASE) begin
            dig_char = ita_pkg::ASCII_ZERO + {4'b0, r_stack[0]};
        end else if (r_upper) begin
            dig_char = ita_pkg::UPPER_HEX_OFFSET + {4'b0, r_stack[0]};
        end else begin
            dig_char = ita_pkg::LOWER_HEX_OFFSET + {4'b0, r_stack[0]};
        end
    end

    always_comb begin
        if (r_empty) begin
            emit_char = '0;
        end else if (r_pre_left != 2'd0) begin
            emit_char = pre_char;
        end else begin
            emit_char = dig_char;
        end
    end

    assign o_q_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // While emitting, the output register is either held or refilled below.
            if (out_free && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_v        <= i_q_cmd.value;
                        r_decimal  <= i_q_cmd.decimal;
                        r_upper    <= i_q_cmd.upper;
                        r_neg      <= i_q_cmd.neg;
                        r_empty    <= i_q_cmd.empty;
                        r_pre_ptr  <= i_q_cmd.pre_ptr;
                        r_pre_left <= i_q_cmd.pre_len;
                        r_pre_idx  <= 2'd0;
                        r_lit      <= i_q_cmd.lit;
                        r_cnt      <= '0;
                        r_state    <= i_q_cmd.has_digits ? S_EXTRACT : S_EMIT;
                    end
                end
                S_EXTRACT: begin
                    r_stack[0] <= digit;
                    for (int i = 1; i < DEPTH; i++) begin
                        r_stack[i] <= r_stack[i-1];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    r_v   <= v_next;
                    if (v_next == '0) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_och    <= emit_char;
                        r_oneg   <= r_neg;
                        r_oempty <= r_empty;
                        r_olast  <= is_last;
                        if (r_empty) begin
                            r_empty <= 1'b0;
                        end else if (r_pre_left != 2'd0) begin
                            r_pre_left <= r_pre_left - 1'b1;
                            r_pre_idx  <= r_pre_idx + 1'b1;
                        end else begin
                            for (int i = 0; i < DEPTH - 1; i++) begin
                                r_stack[i] <= r_stack[i+1];
                            end
                            r_cnt <= r_cnt - 1'b1;
                        end
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_chr.valid       = r_ov;
    assign o_chr.out_char    = r_och;
    assign o_chr.is_negative = r_oneg;
    assign o_chr.empty_res   = r_oempty;
    assign o_chr.last        = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXTRACT) |-> (r_cnt < CW'(DEPTH)))
        else $error("Digit stack overflow during extraction.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_empty || r_pre_left != 2'd0 || r_cnt != '0))
        else $error("Emission ran out of characters before the last one.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oempty) |-> (r_olast && !r_oneg))
        else $error("Empty result is not a lone final transaction.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && is_last) |=> (r_state == S_IDLE && r_olast))
        else $error("Final character did not return the generator to idle.");

endmodule

// File: hdl/int_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// int_to_ascii_formatter
// Converts one request into ASCII characters, most significant first.
// ----------------------------------------------------------------------------
//   Port     Dir  Carries
//   i_req    in   action, value, precision_zero
//   o_chr    out  out_char, is_negative, empty_res, last
//
// A request with digits is dequeued, its digits are extracted, and then
// each of its characters is emitted in turn.
// Decimal digit extraction does one divide-by-ten multiply per cycle.
// Reset is synchronous and clears the queue and the generator state.
// A two-entry queue lets requests enter while characters are stalled.
// ----------------------------------------------------------------------------
module int_to_ascii_formatter #(
    parameter int POINTER_DIGITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ita_req_if.sink   i_req,
    ita_chr_if.source o_chr
);

    localparam int PTR_NIBS  = (POINTER_DIGITS < ita_pkg::VALUE_W / ita_pkg::NIB_W)
                               ? POINTER_DIGITS : ita_pkg::VALUE_W / ita_pkg::NIB_W;
    localparam int DEC_DIGITS = 10;
    localparam int DIG_DEPTH  = (PTR_NIBS > DEC_DIGITS) ? PTR_NIBS : DEC_DIGITS;

    logic          f_valid;
    logic          f_ready;
    ita_pkg::t_cmd f_cmd;
    logic          b_valid;
    logic          b_ready;
    ita_pkg::t_cmd b_cmd;

    ita_front #(
        .POINTER_DIGITS (POINTER_DIGITS)
    ) u_front (
        .i_req     (i_req),
        .i_q_ready (f_ready),
        .o_q_valid (f_valid),
        .o_q_cmd   (f_cmd)
    );

    ita_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_cmd    (b_cmd)
    );

    ita_back #(
        .DEPTH (DIG_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (b_valid),
        .o_q_ready (b_ready),
        .i_q_cmd   (b_cmd),
        .o_chr     (o_chr)
    );

endmodule

// File: verif/ita_fmt_checker.sv
// ----------------------------------------------------------------------------
// ita_fmt_checker
// Watches the request and character channels of the integer to ASCII
// formatter. Each accepted request is converted into the characters the
// block must produce. Each accepted character is compared field by field
// with the oldest one still waiting. The failure count, the number of
// characters still waiting and the number checked go back to the top.
// ----------------------------------------------------------------------------
module ita_fmt_checker #(
    parameter int PTR_DIGITS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ita_req_if   req_mon,
    ita_chr_if   chr_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       neg;
        logic       empty;
        logic       last;
    } t_exp_chr;

    t_exp_chr expected_chars[$];
    int       fail_total  = 0;
    int       checked_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic [7:0] alpha);
        return (nib < ita_pkg::DEC_BASE) ? ita_pkg::ASCII_ZERO + 8'(nib) : alpha + 8'(nib);
    endfunction

    function automatic void format_request(input logic [2:0] act, input logic [47:0] val,
                                           input logic pz);
        logic [7:0]      text[$];
        logic [7:0]      digits[$];
        longint unsigned mag;
        logic [7:0]      alpha;
        logic            neg;
        logic            blank;
        int              pd;
        int              ndig;
        t_exp_chr        item;
        neg   = 1'b0;
        blank = 1'b0;
        alpha = ita_pkg::LOWER_HEX_OFFSET;
        case (act)
            ita_pkg::A_SDEC, ita_pkg::A_UDEC: begin
                mag = val[31:0];
                if (act == ita_pkg::A_SDEC && val[31]) begin
                    neg = 1'b1;
                    mag = 64'h1_0000_0000 - mag;
                end
                if (mag == 0) begin
                    if (pz) blank = 1'b1;
                    else text.push_back(ita_pkg::ASCII_ZERO);
                end
                while (mag != 0) begin
                    text.push_front(ita_pkg::ASCII_ZERO + 8'(mag % 10));
                    mag = mag / 10;
                end
            end
            ita_pkg::A_HEX_LO, ita_pkg::A_HEX_UP: begin
                alpha = (act == ita_pkg::A_HEX_UP) ? ita_pkg::UPPER_HEX_OFFSET
                                                   : ita_pkg::LOWER_HEX_OFFSET;
                mag   = val[31:0];
                if (mag == 0) begin
                    if (pz) blank = 1'b1;
                    else text.push_back(ita_pkg::ASCII_ZERO);
                end
                while (mag != 0) begin
                    text.push_front(hex_digit(mag[3:0], alpha));
                    mag = mag >> 4;
                end
            end
            ita_pkg::A_POINTER: begin
                text.push_back(ita_pkg::ASCII_ZERO);
                text.push_back(ita_pkg::ASCII_X);
                pd = (PTR_DIGITS < 1) ? 1 : (PTR_DIGITS > 16) ? 16 : PTR_DIGITS;
                if (val == 0) begin
                    if (!pz) text.push_back(ita_pkg::ASCII_ZERO);
                end else begin
                    mag = val;
                    if (pd < 16) mag = mag & ((64'd1 << (4 * pd)) - 64'd1);
                    if (mag == 0) begin
                        text.push_back(ita_pkg::ASCII_ZERO);
                    end else begin
                        ndig = 0;
                        while (mag != 0 && ndig < pd) begin
                            digits.push_front(hex_digit(mag[3:0], ita_pkg::LOWER_HEX_OFFSET));
                            mag  = mag >> 4;
                            ndig = ndig + 1;
                        end
                        text = {text, digits};
                    end
                end
            end
            ita_pkg::A_CHAR:    text.push_back(val[7:0]);
            ita_pkg::A_PERCENT: text.push_back(ita_pkg::ASCII_PERCENT);
            default:            blank = 1'b1;
        endcase
        if (blank) begin
            item = '{ch: 8'd0, neg: 1'b0, empty: 1'b1, last: 1'b1};
            expected_chars.push_back(item);
        end else begin
            for (int i = 0; i < text.size(); i++) begin
                item = '{ch: text[i], neg: neg, empty: 1'b0, last: (i == text.size() - 1)};
                expected_chars.push_back(item);
            end
        end
    endfunction

    function automatic void compare_char(input t_exp_chr got);
        t_exp_chr want;
        if (expected_chars.size() == 0) begin
            fail_total = fail_total + 1;
            if (fail_total <= REPORT_LIMIT)
                $display("[%0t] unexpected character: char %h neg %b empty %b last %b",
                         $realtime, got.ch, got.neg, got.empty, got.last);
        end else begin
            want = expected_chars.pop_front();
            checked_total = checked_total + 1;
            if (got !== want) begin
                fail_total = fail_total + 1;
                if (fail_total <= REPORT_LIMIT)
                    $display({"[%0t] mismatch: expected char %h neg %b empty %b last %b,",
                              " got char %h neg %b empty %b last %b"}, $realtime,
                             want.ch, want.neg, want.empty, want.last,
                             got.ch, got.neg, got.empty, got.last);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_mon.valid && req_mon.ready)
                format_request(req_mon.action, req_mon.value, req_mon.precision_zero);
            if (chr_mon.valid && chr_mon.ready)
                compare_char('{ch: chr_mon.out_char, neg: chr_mon.is_negative,
                               empty: chr_mon.empty_res, last: chr_mon.last});
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_chars.size();
        o_checked    <= checked_total;
    end

endmodule

// File: verif/tb_int_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_int_to_ascii_formatter
// Drives conversion requests into the formatter and gives the verdict.
// A directed set covers the edges of every conversion kind; random requests
// follow under three idle profiles, with a full drain between profiles.
// The checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_int_to_ascii_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PTR_DIGITS   = 12;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         RANDOM_REQS  = 250;
    localparam logic [2:0] A_UNUSED     = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   sent_count;
    int   fail_count;
    int   pending_count;
    int   checked_count;

    ita_req_if req_if();
    ita_chr_if chr_if();

    int_to_ascii_formatter #(
        .POINTER_DIGITS(PTR_DIGITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_chr  (chr_if)
    );

    ita_fmt_checker #(
        .PTR_DIGITS(PTR_DIGITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req_mon     (req_if),
        .chr_mon     (chr_if),
        .o_fail_count(fail_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        chr_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_req(input logic [2:0] act, input logic [47:0] val, input logic pz);
        if ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_if.valid          <= 1'b1;
        req_if.action         <= act;
        req_if.value          <= val;
        req_if.precision_zero <= pz;
        do @(posedge i_clk); while (!req_if.ready);
        sent_count = sent_count + 1;
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [47:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(6))
            0:       return 48'd0;
            1:       return r[47:0] & 48'hFF;
            2:       return {r[47:32], 32'h8000_0000};
            3:       return {r[47:32], 32'hFFFF_FFFF};
            4:       return r[47:0] >> $urandom_range(47);
            default: return r[47:0];
        endcase
    endfunction

    initial begin
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.action         = ita_pkg::A_SDEC;
        req_if.value          = '0;
        req_if.precision_zero = 1'b0;
        chr_if.ready          = 1'b0;
        src_idle_pct          = 29;
        sink_idle_pct         = 71;
        sent_count            = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(ita_pkg::A_SDEC,    48'h0,              1'b0);
        send_req(ita_pkg::A_SDEC,    48'h0,              1'b1);
        send_req(ita_pkg::A_SDEC,    48'h0000_7FFF_FFFF, 1'b0);
        send_req(ita_pkg::A_SDEC,    48'h0000_8000_0000, 1'b1);
        send_req(ita_pkg::A_SDEC,    48'hFFFF_FFFF_FFFF, 1'b0);
        send_req(ita_pkg::A_UDEC,    48'h0000_FFFF_FFFF, 1'b0);
        send_req(ita_pkg::A_UDEC,    48'h0,              1'b1);
        send_req(ita_pkg::A_UDEC,    48'hABCD_0000_0007, 1'b0);
        send_req(ita_pkg::A_HEX_LO,  48'h0000_DEAD_BEEF, 1'b0);
        send_req(ita_pkg::A_HEX_UP,  48'h1234_DEAD_BEEF, 1'b1);
        send_req(ita_pkg::A_HEX_LO,  48'h0,              1'b0);
        send_req(ita_pkg::A_HEX_UP,  48'h0,              1'b1);
        send_req(ita_pkg::A_HEX_UP,  48'h0000_FFFF_FFFF, 1'b0);
        send_req(ita_pkg::A_POINTER, 48'h0,              1'b0);
        send_req(ita_pkg::A_POINTER, 48'h0,              1'b1);
        send_req(ita_pkg::A_POINTER, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_req(ita_pkg::A_POINTER, 48'h0000_0000_0001, 1'b1);
        send_req(ita_pkg::A_POINTER, 48'h8000_0000_0000, 1'b0);
        send_req(ita_pkg::A_CHAR,    48'h0,              1'b0);
        send_req(ita_pkg::A_CHAR,    48'hFFFF_FFFF_FFFF, 1'b1);
        send_req(ita_pkg::A_CHAR,    48'h0000_0000_0041, 1'b0);
        send_req(ita_pkg::A_PERCENT, 48'h5A5A_5A5A_5A5A, 1'b1);
        send_req(A_UNUSED,           48'h0000_0000_0123, 1'b0);
        send_req(A_UNUSED,           48'h0,              1'b1);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 71 : 0;
            sink_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 29 : 0;
            for (int n = 0; n < RANDOM_REQS / 3; n++)
                send_req(3'($urandom_range(7)), pick_value(), 1'($urandom_range(1)));
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d requests over all seven kinds and the unused code,", sent_count);
        $display("summary: %0d characters checked under three idle profiles", checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
